/* hdl/wdoc_pkg.sv */
// Package for the windowed depth outlier compare block: widths, register
// indexes and shared types. No dependencies.
`default_nettype none
package wdoc_pkg;
   localparam int MaxWindow  = 1024;
   localparam int NumSamples = 4;
   localparam int Lanes      = 4;
   localparam int HistAw     = $clog2(MaxWindow);
   localparam int LenW       = 11;
   localparam int SumW       = 26;
   localparam int PosW       = 31;
   localparam int DepW       = 16;
   localparam int AddrW      = 3;

   localparam logic [AddrW-1:0] RegLength  = 3'd0;
   localparam logic [AddrW-1:0] RegStep    = 3'd1;
   localparam logic [AddrW-1:0] RegPeak    = 3'd2;
   localparam logic [AddrW-1:0] RegRatio   = 3'd3;
   localparam logic [AddrW-1:0] RegSamples = 3'd4;

   typedef struct packed {
      logic            region_first;
      logic [PosW-1:0] position;
      logic [DepW-1:0] depth_s0;
      logic [DepW-1:0] depth_s1;
      logic [DepW-1:0] depth_s2;
      logic [DepW-1:0] depth_s3;
   } req_type;

   typedef struct packed {
      logic [PosW-1:0] window_begin;
      logic [DepW-1:0] mean_s0;
      logic [DepW-1:0] mean_s1;
      logic [DepW-1:0] mean_s2;
      logic [DepW-1:0] mean_s3;
      logic [DepW-1:0] mean_all;
      logic [3:0]      outlier_mask;
      logic [DepW-1:0] largest_diff;
   } rsp_type;

   // divider control between sequencer and divider
   typedef struct packed {
      logic            start;
      logic [47:0]     dividend;
      logic [23:0]     divisor;
   } div_cmd_type;
endpackage
`default_nettype wire

/* hdl/wdoc_if.sv */
// Valid/ready channel interface carrying one payload type.
// Depends on wdoc_pkg.
`default_nettype none
interface wdoc_req_if;
   logic              valid;
   logic              ready;
   wdoc_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface wdoc_rsp_if;
   logic              valid;
   logic              ready;
   wdoc_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/wdoc_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle, 48 by 24 bits.
// Depends on wdoc_pkg.
`default_nettype none
module wdoc_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wdoc_pkg::div_cmd_type cmd,
   output logic                      done,
   output logic [47:0]               quotient
);
   logic [47:0] quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic [23:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [24:0] trial;

   assign trial = {rem_ff[23:0], quo_ff[47]} - {1'b0, dvs_ff};

   // shift one dividend bit in per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[24]) begin
            rem_in = trial;
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = {rem_ff[23:0], quo_ff[47]};
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign done     = busy_ff && (cnt_ff == 6'd1);
   assign quotient = quo_in;
endmodule
`default_nettype wire

/* hdl/windowed_depth_outlier_compare.sv */
// Top level of the windowed depth outlier compare block: window sums,
// history ring, sequencer and CSRs. Depends on wdoc_pkg, wdoc_if, wdoc_div.
//
//   channel  | dir | handshake           | payload
//   req      | in  | valid/ready         | region_first, position, depth_s0..3
//   rsp      | out | valid/ready         | window_begin, means, mask, diff
//   csr      | in  | APB psel/penable    | 5 registers at 4*i
//
// A request that closes no window passes through accept, ring read and sum
// update. A closing window adds a scan of the S lane sums, one peak check,
// 2*S compare steps through one shared 28 x 16 multiplier and six divisions in
// the shared divider. A dropped window returns after the peak check. Reset is
// synchronous; the result waits in the output register and a new request is
// taken while it waits.
`default_nettype none
module windowed_depth_outlier_compare (
   input  wire logic        clock,
   input  wire logic        reset,
   wdoc_req_if.sink         req,
   wdoc_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int HAw  = wdoc_pkg::HistAw;
   localparam int LW   = wdoc_pkg::LenW;
   localparam int SW   = wdoc_pkg::SumW;
   localparam int PW   = wdoc_pkg::PosW;
   localparam int DW   = wdoc_pkg::DepW;

   typedef enum logic [8:0] {
      StIdle  = 9'b000000001,
      StRead  = 9'b000000010,
      StSum   = 9'b000000100,
      StScan  = 9'b000001000,
      StPeak  = 9'b000010000,
      StMask  = 9'b000100000,
      StDiv   = 9'b001000000,
      StWait  = 9'b010000000,
      StOut   = 9'b100000000
   } state_type;

   // configuration registers
   logic [LW-1:0] len_ff, step_ff;
   logic [15:0]   peak_ff, ratio_ff;
   logic [2:0]    smp_ff;
   logic          wr_en;
   logic [2:0]    reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= LW'(50);
         step_ff  <= LW'(25);
         peak_ff  <= '0;
         ratio_ff <= 16'd512;
         smp_ff   <= 3'd4;
      end else if (wr_en) begin
         case (reg_idx)
            wdoc_pkg::RegLength:  len_ff   <= csr_pwdata[LW-1:0];
            wdoc_pkg::RegStep:    step_ff  <= csr_pwdata[LW-1:0];
            wdoc_pkg::RegPeak:    peak_ff  <= csr_pwdata[15:0];
            wdoc_pkg::RegRatio:   ratio_ff <= csr_pwdata[15:0];
            wdoc_pkg::RegSamples: smp_ff   <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         wdoc_pkg::RegLength:  csr_prdata = {21'd0, len_ff};
         wdoc_pkg::RegStep:    csr_prdata = {21'd0, step_ff};
         wdoc_pkg::RegPeak:    csr_prdata = {16'd0, peak_ff};
         wdoc_pkg::RegRatio:   csr_prdata = {16'd0, ratio_ff};
         wdoc_pkg::RegSamples: csr_prdata = {29'd0, smp_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // effective length, step and sample count
   logic [LW-1:0] eff_len, eff_step;
   logic [2:0]    eff_smp;
   always_comb begin
      eff_len = len_ff;
      if (len_ff == '0) eff_len = LW'(1);
      if (len_ff > LW'(wdoc_pkg::MaxWindow)) eff_len = LW'(wdoc_pkg::MaxWindow);
      eff_step = (step_ff == '0) ? LW'(1) : step_ff;
      eff_smp = smp_ff;
      if (smp_ff < 3'd2) eff_smp = 3'd2;
      if (smp_ff > 3'(wdoc_pkg::Lanes)) eff_smp = 3'(wdoc_pkg::Lanes);
   end

   // block state
   state_type     st_ff, st_in;
   logic [SW-1:0] sum_ff [wdoc_pkg::Lanes];
   logic [PW-1:0] seen_ff, origin_ff;
   logic [LW-1:0] cnt_ff;
   logic [HAw-1:0] head_ff;
   wdoc_pkg::req_type item_ff;
   logic [63:0]   hist_mem [wdoc_pkg::MaxWindow];
   logic [63:0]   old_ff;
   logic          mem_we;
   logic [HAw-1:0] rd_addr;
   logic [63:0]   wr_word;

   // compare sequence registers
   logic [SW+1:0] tot_ff;
   logic [SW-1:0] mx_ff, mn_ff;
   logic [1:0]    idx_ff;
   logic [3:0]    mask_ff;
   logic [2:0]    dsel_ff;
   logic [DW-1:0] res_ff [6];
   wdoc_pkg::rsp_type out_ff;
   logic          ovalid_ff;

   assign req.ready = (st_ff == StIdle);

   assign rd_addr = head_ff - eff_len[HAw-1:0];
   assign wr_word = {item_ff.depth_s3, item_ff.depth_s2, item_ff.depth_s1,
                     item_ff.depth_s0};
   assign mem_we  = (st_ff == StSum);

   always_ff @(posedge clock) begin
      if (mem_we) hist_mem[head_ff] <= wr_word;
      old_ff <= hist_mem[rd_addr];
   end

   // shared multiply unit: one 28 x 16 product per cycle, operand picked by phase
   logic [SW-1:0] ti;
   logic [SW+1:0] others;
   logic [2:0]    km1;
   assign ti     = sum_ff[idx_ff];
   assign others = tot_ff - {2'b0, ti};
   assign km1    = eff_smp - 3'd1;

   logic          phase_ff;
   logic [63:0]   mul_a, mul_in, prod;
   logic          lt_bit;
   // phase 0: t*(k-1)*R vs O*256 ; phase 1: t*(k-1)*256 vs O*R
   always_comb begin
      mul_a  = 64'(ti) * 64'(km1);
      mul_in = phase_ff ? 64'(others) : mul_a;
      prod   = 64'(mul_in[SW+1:0]) * 64'(ratio_ff);
      lt_bit = phase_ff ? ((mul_a << 8) > prod) : (prod < (64'(others) << 8));
   end

   // divider
   wdoc_pkg::div_cmd_type dcmd;
   logic        ddone;
   logic [47:0] dq;
   logic        dstart;
   wdoc_div u_div (.clock(clock), .reset(reset), .cmd(dcmd), .done(ddone),
                   .quotient(dq));

   logic [47:0] dnd;
   logic [23:0] dvs;
   always_comb begin
      dvs = 24'(eff_len);
      case (dsel_ff)
         3'd0: dnd = 48'(sum_ff[0]);
         3'd1: dnd = 48'(sum_ff[1]);
         3'd2: dnd = 48'(sum_ff[2]);
         3'd3: dnd = 48'(sum_ff[3]);
         3'd4: begin
            dnd = 48'(tot_ff);
            dvs = 24'(eff_len) * 24'(eff_smp);
         end
         default: dnd = 48'(mx_ff - mn_ff);
      endcase
   end
   assign dcmd.start    = dstart;
   assign dcmd.dividend = dnd;
   assign dcmd.divisor  = dvs;

   logic full_before;
   logic [LW-1:0] c_eff;
   assign full_before = seen_ff >= PW'(eff_len);
   assign c_eff = ((cnt_ff == '0) ? eff_len : cnt_ff) - LW'(1);
   assign dstart = (st_ff == StDiv);

   // sequencer
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         StIdle: if (req.valid) st_in = StRead;
         StRead: st_in = StSum;
         StSum:  st_in = (c_eff == '0 && (seen_ff + PW'(1) >= PW'(eff_len)
                          || seen_ff == '1 && PW'(eff_len) <= seen_ff))
                          ? StScan : StIdle;
         StScan: st_in = (idx_ff == 2'(eff_smp - 3'd1)) ? StPeak : StScan;
         StPeak: st_in = (64'(mx_ff) < 64'(peak_ff) * 64'(eff_len)) ? StIdle : StMask;
         StMask: st_in = (phase_ff && idx_ff == 2'(eff_smp - 3'd1)) ? StDiv : StMask;
         StDiv:  st_in = StWait;
         StWait: if (ddone) st_in = (dsel_ff == 3'd5) ? StOut : StDiv;
         StOut:  if (!ovalid_ff || rsp.ready) st_in = StIdle;
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= StIdle;
         for (int s = 0; s < wdoc_pkg::Lanes; s++) sum_ff[s] <= '0;
         seen_ff   <= '0;
         origin_ff <= '0;
         cnt_ff    <= '0;
         head_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         // raise valid when a result is loaded, drop it once taken
         if (st_ff == StOut && (!ovalid_ff || rsp.ready)) ovalid_ff <= 1'b1;
         else if (rsp.ready) ovalid_ff <= 1'b0;
         case (st_ff)
            StIdle: if (req.valid) begin
               item_ff <= req.data;
               if (req.data.region_first) begin
                  for (int s = 0; s < wdoc_pkg::Lanes; s++) sum_ff[s] <= '0;
                  seen_ff   <= '0;
                  origin_ff <= req.data.position;
                  cnt_ff    <= '0;
               end
            end
            StSum: begin
               for (int s = 0; s < wdoc_pkg::Lanes; s++)
                  sum_ff[s] <= sum_ff[s]
                     - (full_before ? SW'(old_ff[16*s +: 16]) : SW'(0))
                     + SW'(wr_word[16*s +: 16]);
               head_ff <= head_ff + HAw'(1);
               if (seen_ff != '1) seen_ff <= seen_ff + PW'(1);
               cnt_ff  <= (c_eff == '0) ? eff_step : c_eff;
               idx_ff  <= '0;
               tot_ff  <= '0;
               mx_ff   <= '0;
               mn_ff   <= '1;
            end
            StScan: begin
               tot_ff <= tot_ff + {2'b0, ti};
               if (ti > mx_ff) mx_ff <= ti;
               if (ti < mn_ff) mn_ff <= ti;
               idx_ff <= idx_ff + 2'd1;
            end
            StPeak: begin
               idx_ff   <= '0;
               phase_ff <= 1'b0;
               mask_ff  <= '0;
               dsel_ff  <= '0;
            end
            StMask: begin
               if (lt_bit) mask_ff[idx_ff] <= 1'b1;
               phase_ff <= !phase_ff;
               if (phase_ff) idx_ff <= idx_ff + 2'd1;
            end
            StWait: if (ddone) begin
               res_ff[dsel_ff] <= (dq > 48'd65535) ? 16'hFFFF : dq[15:0];
               dsel_ff <= dsel_ff + 3'd1;
            end
            StOut: if (!ovalid_ff || rsp.ready) begin
               out_ff.window_begin <= origin_ff + seen_ff - PW'(eff_len);
               out_ff.mean_s0 <= res_ff[0];
               out_ff.mean_s1 <= res_ff[1];
               out_ff.mean_s2 <= (eff_smp > 3'd2) ? res_ff[2] : '0;
               out_ff.mean_s3 <= (eff_smp > 3'd3) ? res_ff[3] : '0;
               out_ff.mean_all <= res_ff[4];
               out_ff.outlier_mask <= mask_ff;
               out_ff.largest_diff <= res_ff[5];
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid = ovalid_ff;
   assign rsp.data  = out_ff;
endmodule
`default_nettype wire
